>>> sv/fssl_pkg.sv
// ---------------------------------------------------------------------------
// fssl_pkg
// Shared codes, widths and queue entry type of the slave-serial loader.
// ---------------------------------------------------------------------------
`default_nettype none

package fssl_pkg;

	// command opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_POLL  = 2'd2;

	// reported status
	localparam logic [1:0] ST_BUSY       = 2'd0;
	localparam logic [1:0] ST_CONFIGURED = 2'd1;
	localparam logic [1:0] ST_TIMEOUT    = 2'd2;

	// job kinds handed to the sequencer
	localparam logic [1:0] JOB_START = 2'd0;
	localparam logic [1:0] JOB_DATA  = 2'd1;
	localparam logic [1:0] JOB_TRAIL = 2'd2;
	localparam logic [1:0] JOB_WAIT  = 2'd3;

	localparam int PULSE_CAP = 10;   // most trailing pulses per poll
	localparam int BYTE_W    = 8;
	localparam int WAIT_W    = 17;
	localparam int MAXW_W    = 16;
	localparam int STEP_W    = 5;    // up to twenty snapshots per job
	localparam int QDEPTH    = 2;
	localparam int QIDX_W    = 1;

	localparam logic [STEP_W-1:0] START_LAST = STEP_W'(2);
	localparam logic [STEP_W-1:0] DATA_LAST  = STEP_W'(2 * BYTE_W - 1);
	localparam logic [STEP_W-1:0] WAIT_LAST  = STEP_W'(1);

	localparam logic [MAXW_W-1:0] MAX_WAIT_RST = MAXW_W'(1000);

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] data;
		logic [1:0]        status;
	} fssl_job_t;

endpackage

`default_nettype wire

>>> sv/fssl_if.sv
// ---------------------------------------------------------------------------
// fssl_cmd_if / fssl_snap_if
// Valid/ready channels for command beats and pin snapshot beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface fssl_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;
	logic       done_level;

	modport source (output valid, op, data_byte, done_level, input ready);
	modport sink   (input valid, op, data_byte, done_level, output ready);
endinterface

interface fssl_snap_if;
	logic       valid;
	logic       ready;
	logic       prog_level;
	logic       cclk_level;
	logic       din_level;
	logic [1:0] status;
	logic       last;

	modport source (output valid, prog_level, cclk_level, din_level, status, last,
		input ready);
	modport sink   (input valid, prog_level, cclk_level, din_level, status, last,
		output ready);
endinterface

`default_nettype wire

>>> sv/fssl_front.sv
// ---------------------------------------------------------------------------
// fssl_front
// Takes command beats, keeps the done-wait count and turns each start, data
// or poll command into a sequencer job.
// ---------------------------------------------------------------------------
`default_nettype none

module fssl_front
	import fssl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	fssl_cmd_if.sink               cmd,
	input  wire logic [MAXW_W-1:0] max_wait,
	input  wire logic              q_full,
	output logic                   push,
	output fssl_job_t              job
);

	logic [WAIT_W-1:0] wait_count_q;
	logic [WAIT_W-1:0] wait_inc;
	logic              timeout;
	logic              take;

	assign cmd.ready = !q_full;
	assign take      = cmd.valid && cmd.ready;
	assign wait_inc  = wait_count_q + WAIT_W'(1);
	assign timeout   = wait_inc > {1'b0, max_wait};

	always_comb begin
		push        = 1'b0;
		job.kind    = JOB_START;
		job.data    = cmd.data_byte;
		job.status  = ST_BUSY;
		case (cmd.op)
			OP_START: begin
				push = take;
			end
			OP_DATA: begin
				push     = take;
				job.kind = JOB_DATA;
			end
			OP_POLL: begin
				push = take;
				if (cmd.done_level) begin
					job.kind   = JOB_TRAIL;
					job.status = ST_CONFIGURED;
				end else begin
					job.kind   = JOB_WAIT;
					job.status = timeout ? ST_TIMEOUT : ST_BUSY;
				end
			end
			default: begin
				push = 1'b0;   // unused opcode: dropped
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_count_q <= '0;
		end else if (take) begin
			case (cmd.op)
				OP_START: wait_count_q <= '0;
				OP_POLL: begin
					if (cmd.done_level || timeout)
						wait_count_q <= '0;
					else
						wait_count_q <= wait_inc;
				end
				default: wait_count_q <= wait_count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/fssl_queue.sv
// ---------------------------------------------------------------------------
// fssl_queue
// Entry storage of the two-entry job queue: one write port, one read port.
// ---------------------------------------------------------------------------
`default_nettype none

module fssl_queue
	import fssl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [QIDX_W-1:0] waddr,
	input  wire fssl_job_t         wdata,
	input  wire logic [QIDX_W-1:0] raddr,
	output fssl_job_t              rdata
);

	fssl_job_t ent_q [QDEPTH];

	always_ff @(posedge clk) begin
		if (we)
			ent_q[waddr] <= wdata;
	end

	assign rdata = ent_q[raddr];

endmodule

`default_nettype wire

>>> sv/fssl_fifo.sv
// ---------------------------------------------------------------------------
// fssl_fifo
// Two-entry job queue between the command front and the pin sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module fssl_fifo
	import fssl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire fssl_job_t wr_job,
	output logic           full,
	input  wire logic      pop,
	output logic           valid,
	output fssl_job_t      rd_job
);

	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [QIDX_W-1:0] wptr_q;
	logic [QIDX_W-1:0] rptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              do_pop;

	assign full   = fill_q == CNT_W'(QDEPTH);
	assign valid  = fill_q != '0;
	assign do_pop = pop && valid;

	fssl_queue u_store (
		.clk   (clk),
		.we    (push),
		.waddr (wptr_q),
		.wdata (wr_job),
		.raddr (rptr_q),
		.rdata (rd_job)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wptr_q + QIDX_W'(1);
			if (do_pop)
				rptr_q <= (rptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : rptr_q + QIDX_W'(1);
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/fssl_back.sv
// ---------------------------------------------------------------------------
// fssl_back
// Pin sequencer: plays one job as a run of pin snapshots into an output
// register, one snapshot per cycle while snap is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module fssl_back
	import fssl_pkg::*;
#(
	parameter int TRAIL_CLOCKS = 10
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire fssl_job_t job,
	input  wire logic      q_valid,
	output logic           q_pop,
	fssl_snap_if.source    snap
);

	localparam int TRAIL_N = (TRAIL_CLOCKS < PULSE_CAP) ? TRAIL_CLOCKS : PULSE_CAP;
	localparam logic TRAIL_NONE = (TRAIL_N == 0);
	localparam logic [STEP_W-1:0] TRAIL_LAST =
		STEP_W'((TRAIL_N == 0) ? 0 : 2 * TRAIL_N - 1);

	logic              busy_q;
	logic [1:0]        kind_q;
	logic [BYTE_W-1:0] sh_q;
	logic [1:0]        stat_q;
	logic [STEP_W-1:0] step_q;

	logic              ov_q;
	logic              prog_q, cclk_q, din_q, last_q;
	logic [1:0]        status_q;

	logic              out_free, emit, is_last, load;
	logic [STEP_W-1:0] last_step;
	logic              n_prog, n_cclk, n_din;

	assign out_free = !ov_q || snap.ready;
	assign emit     = busy_q && out_free;

	always_comb begin
		case (kind_q)
			JOB_START: last_step = START_LAST;
			JOB_DATA:  last_step = DATA_LAST;
			JOB_TRAIL: last_step = TRAIL_LAST;
			default:   last_step = WAIT_LAST;
		endcase
	end

	assign is_last = step_q == last_step;
	assign load    = q_valid && (!busy_q || (emit && is_last));
	assign q_pop   = load;

	always_comb begin
		n_prog = 1'b1;
		n_cclk = !step_q[0];
		n_din  = 1'b1;
		case (kind_q)
			JOB_START: begin
				n_prog = step_q != STEP_W'(1);
				n_cclk = 1'b1;
			end
			JOB_DATA:  n_din  = sh_q[BYTE_W-1];
			JOB_TRAIL: n_cclk = !step_q[0] && !TRAIL_NONE;
			default:   n_cclk = !step_q[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (emit) begin
				busy_q <= !is_last;
				step_q <= step_q + STEP_W'(1);
			end
			if (emit)
				ov_q <= 1'b1;
			else if (snap.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= job.kind;
			sh_q   <= job.data;
			stat_q <= job.status;
		end else if (emit && step_q[0]) begin
			sh_q <= {sh_q[BYTE_W-2:0], 1'b0};
		end
		if (emit) begin
			prog_q   <= n_prog;
			cclk_q   <= n_cclk;
			din_q    <= n_din;
			last_q   <= is_last;
			status_q <= is_last ? stat_q : ST_BUSY;
		end
	end

	assign snap.valid      = ov_q;
	assign snap.prog_level = prog_q;
	assign snap.cclk_level = cclk_q;
	assign snap.din_level  = din_q;
	assign snap.status     = status_q;
	assign snap.last       = last_q;

endmodule

`default_nettype wire

>>> sv/fpga_slave_serial_loader.sv
// ---------------------------------------------------------------------------
// fpga_slave_serial_loader
// Slave-serial configuration pin sequencer: commands in, pin snapshots out.
// ---------------------------------------------------------------------------
// Each command beat on cmd becomes a run of pin snapshot beats on snap, one
// snapshot per cycle while snap is ready: a start gives 3 snapshots, a data
// byte 16 (MSB first, clock high then low per bit), a poll with done low 2,
// and a poll with done high 2*min(TRAIL_CLOCKS,10) (1 when TRAIL_CLOCKS is 0).
// The pin sequencer's one-snapshot-per-cycle output register sets the rate,
// so a stream of data bytes moves with no gaps between commands. Commands are
// taken ahead of time into a two-entry queue, and opcode 3 is taken and
// dropped. Status is nonzero only on the last snapshot of a poll. max_wait is
// written through max_wait_we/max_wait_wdata and must only change while no
// command is outstanding.
// ---------------------------------------------------------------------------
`default_nettype none

module fpga_slave_serial_loader
	import fssl_pkg::*;
#(
	parameter int TRAIL_CLOCKS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	fssl_cmd_if.sink               cmd,
	fssl_snap_if.source            snap,
	input  wire logic              max_wait_we,
	input  wire logic [MAXW_W-1:0] max_wait_wdata
);

	logic [MAXW_W-1:0] max_wait_q;
	logic              q_full;
	logic              push;
	fssl_job_t         wr_job;
	fssl_job_t         rd_job;
	logic              q_valid;
	logic              q_pop;

	// timeout threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_wait_q <= MAX_WAIT_RST;
		else if (max_wait_we)
			max_wait_q <= max_wait_wdata;
	end

	// front: classify commands, keep the done-wait count
	fssl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.max_wait (max_wait_q),
		.q_full   (q_full),
		.push     (push),
		.job      (wr_job)
	);

	// job queue decouples command intake from the pin sequencer
	fssl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rd_job (rd_job)
	);

	// back: play jobs as pin snapshots
	fssl_back #(
		.TRAIL_CLOCKS (TRAIL_CLOCKS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (rd_job),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.snap    (snap)
	);

endmodule

`default_nettype wire
